>>> hdl/csi_pkg.sv
// Shared types, constants and the sequencer program for the cubic spline segment interpolator.
package csi_pkg;

    localparam int VAL_W  = 32;
    localparam int SLOT_W = 5;
    localparam int PC_W   = 6;

    typedef struct packed {
        logic              req_type;
        logic signed [31:0] point_x0;
        logic signed [31:0] point_x1;
        logic signed [31:0] point_x2;
        logic signed [31:0] point_x3;
        logic signed [31:0] point_y0;
        logic signed [31:0] point_y1;
        logic signed [31:0] point_y2;
        logic signed [31:0] point_y3;
        logic signed [31:0] eval_offset;
    } csi_req_t;

    typedef struct packed {
        logic signed [31:0] coef_cubic;
        logic signed [31:0] coef_quadratic;
        logic signed [31:0] coef_linear;
        logic signed [31:0] coef_constant;
        logic signed [31:0] interp_value;
        logic [1:0]         status;
    } csi_rsp_t;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ZERO = 2'd1;
    localparam logic [1:0] STAT_SAT  = 2'd2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_SUB2,
        OP_TRI,
        OP_MUL,
        OP_DIV
    } csi_op_t;

    typedef struct packed {
        logic               start;
        csi_op_t            op;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } csi_alu_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] result;
        logic               sat;
        logic               zero;
    } csi_alu_rsp_t;

    localparam logic [1:0] CAP_C0  = 2'd0;
    localparam logic [1:0] CAP_C1  = 2'd1;
    localparam logic [1:0] CAP_C2  = 2'd2;
    localparam logic [1:0] CAP_VAL = 2'd3;

    typedef struct packed {
        csi_op_t           op;
        logic [SLOT_W-1:0] dst;
        logic [SLOT_W-1:0] src_a;
        logic [SLOT_W-1:0] src_b;
        logic              cap_en;
        logic [1:0]        cap;
        logic              last;
    } csi_step_t;

    localparam logic [SLOT_W-1:0] S_X0   = 5'd0;
    localparam logic [SLOT_W-1:0] S_X1   = 5'd1;
    localparam logic [SLOT_W-1:0] S_X2   = 5'd2;
    localparam logic [SLOT_W-1:0] S_X3   = 5'd3;
    localparam logic [SLOT_W-1:0] S_Y0   = 5'd4;
    localparam logic [SLOT_W-1:0] S_Y1   = 5'd5;
    localparam logic [SLOT_W-1:0] S_Y2   = 5'd6;
    localparam logic [SLOT_W-1:0] S_Y3   = 5'd7;
    localparam logic [SLOT_W-1:0] S_T    = 5'd8;
    localparam logic [SLOT_W-1:0] S_C0   = 5'd9;
    localparam logic [SLOT_W-1:0] S_C1   = 5'd10;
    localparam logic [SLOT_W-1:0] S_C2   = 5'd11;
    localparam logic [SLOT_W-1:0] S_C3   = 5'd12;
    localparam logic [SLOT_W-1:0] S_H0   = 5'd16;
    localparam logic [SLOT_W-1:0] S_H1   = 5'd17;
    localparam logic [SLOT_W-1:0] S_H2   = 5'd18;
    localparam logic [SLOT_W-1:0] S_TA   = 5'd19;
    localparam logic [SLOT_W-1:0] S_D0   = 5'd20;
    localparam logic [SLOT_W-1:0] S_D1   = 5'd21;
    localparam logic [SLOT_W-1:0] S_D2   = 5'd22;
    localparam logic [SLOT_W-1:0] S_TB   = 5'd23;
    localparam logic [SLOT_W-1:0] S_TC   = 5'd24;
    localparam logic [SLOT_W-1:0] S_YD1  = 5'd25;
    localparam logic [SLOT_W-1:0] S_YD2  = 5'd26;
    localparam logic [SLOT_W-1:0] S_R    = 5'd27;
    localparam logic [SLOT_W-1:0] S_Q    = 5'd28;
    localparam logic [SLOT_W-1:0] S_HQ   = 5'd29;
    localparam logic [SLOT_W-1:0] S_H1SQ = 5'd30;
    localparam logic [SLOT_W-1:0] S_H1CU = 5'd31;

    localparam logic [3:0]      INIT_LAST = 4'd12;
    localparam logic [PC_W-1:0] PC_LOAD   = 6'd0;
    localparam logic [PC_W-1:0] PC_EVAL   = 6'd32;

    function automatic csi_step_t mk(input csi_op_t op, input logic [SLOT_W-1:0] dst,
                                     input logic [SLOT_W-1:0] sa, input logic [SLOT_W-1:0] sb,
                                     input logic cen, input logic [1:0] cap, input logic last);
        csi_step_t s;
        s.op     = op;
        s.dst    = dst;
        s.src_a  = sa;
        s.src_b  = sb;
        s.cap_en = cen;
        s.cap    = cap;
        s.last   = last;
        return s;
    endfunction

    function automatic csi_step_t prog_step(input logic [PC_W-1:0] pc);
        csi_step_t s;
        s = mk(OP_ADD, S_TA, S_TA, S_TA, 1'b0, CAP_C0, 1'b1);
        unique case (pc)
            6'd0:  s = mk(OP_SUB,  S_H0,   S_X1,  S_X0,   1'b0, CAP_C0,  1'b0);
            6'd1:  s = mk(OP_SUB,  S_H1,   S_X2,  S_X1,   1'b0, CAP_C0,  1'b0);
            6'd2:  s = mk(OP_SUB,  S_H2,   S_X3,  S_X2,   1'b0, CAP_C0,  1'b0);
            6'd3:  s = mk(OP_SUB,  S_TA,   S_Y1,  S_Y0,   1'b0, CAP_C0,  1'b0);
            6'd4:  s = mk(OP_DIV,  S_D0,   S_TA,  S_H0,   1'b0, CAP_C0,  1'b0);
            6'd5:  s = mk(OP_SUB,  S_TA,   S_Y2,  S_Y1,   1'b0, CAP_C0,  1'b0);
            6'd6:  s = mk(OP_DIV,  S_D1,   S_TA,  S_H1,   1'b0, CAP_C0,  1'b0);
            6'd7:  s = mk(OP_SUB,  S_TA,   S_Y3,  S_Y2,   1'b0, CAP_C0,  1'b0);
            6'd8:  s = mk(OP_DIV,  S_D2,   S_TA,  S_H2,   1'b0, CAP_C0,  1'b0);
            6'd9:  s = mk(OP_MUL,  S_TA,   S_D1,  S_H0,   1'b0, CAP_C0,  1'b0);
            6'd10: s = mk(OP_MUL,  S_TB,   S_D0,  S_H1,   1'b0, CAP_C0,  1'b0);
            6'd11: s = mk(OP_ADD,  S_TA,   S_TA,  S_TB,   1'b0, CAP_C0,  1'b0);
            6'd12: s = mk(OP_ADD,  S_TB,   S_H0,  S_H1,   1'b0, CAP_C0,  1'b0);
            6'd13: s = mk(OP_DIV,  S_YD1,  S_TA,  S_TB,   1'b1, CAP_C2,  1'b0);
            6'd14: s = mk(OP_MUL,  S_TA,   S_D2,  S_H1,   1'b0, CAP_C0,  1'b0);
            6'd15: s = mk(OP_MUL,  S_TB,   S_D1,  S_H2,   1'b0, CAP_C0,  1'b0);
            6'd16: s = mk(OP_ADD,  S_TA,   S_TA,  S_TB,   1'b0, CAP_C0,  1'b0);
            6'd17: s = mk(OP_ADD,  S_TB,   S_H1,  S_H2,   1'b0, CAP_C0,  1'b0);
            6'd18: s = mk(OP_DIV,  S_YD2,  S_TA,  S_TB,   1'b0, CAP_C0,  1'b0);
            6'd19: s = mk(OP_SUB,  S_TA,   S_Y2,  S_Y1,   1'b0, CAP_C0,  1'b0);
            6'd20: s = mk(OP_MUL,  S_TB,   S_H1,  S_YD1,  1'b0, CAP_C0,  1'b0);
            6'd21: s = mk(OP_SUB,  S_R,    S_TA,  S_TB,   1'b0, CAP_C0,  1'b0);
            6'd22: s = mk(OP_SUB,  S_Q,    S_YD2, S_YD1,  1'b0, CAP_C0,  1'b0);
            6'd23: s = mk(OP_MUL,  S_HQ,   S_H1,  S_Q,    1'b0, CAP_C0,  1'b0);
            6'd24: s = mk(OP_MUL,  S_H1SQ, S_H1,  S_H1,   1'b0, CAP_C0,  1'b0);
            6'd25: s = mk(OP_MUL,  S_H1CU, S_H1SQ, S_H1,  1'b0, CAP_C0,  1'b0);
            6'd26: s = mk(OP_SUB2, S_TA,   S_HQ,  S_R,    1'b0, CAP_C0,  1'b0);
            6'd27: s = mk(OP_DIV,  S_TB,   S_TA,  S_H1CU, 1'b1, CAP_C0,  1'b0);
            6'd28: s = mk(OP_TRI,  S_TA,   S_R,   S_HQ,   1'b0, CAP_C0,  1'b0);
            6'd29: s = mk(OP_DIV,  S_TC,   S_TA,  S_H1SQ, 1'b1, CAP_C1,  1'b1);
            6'd32: s = mk(OP_MUL,  S_TA,   S_C0,  S_T,    1'b0, CAP_C0,  1'b0);
            6'd33: s = mk(OP_ADD,  S_TA,   S_C1,  S_TA,   1'b0, CAP_C0,  1'b0);
            6'd34: s = mk(OP_MUL,  S_TA,   S_T,   S_TA,   1'b0, CAP_C0,  1'b0);
            6'd35: s = mk(OP_ADD,  S_TA,   S_C2,  S_TA,   1'b0, CAP_C0,  1'b0);
            6'd36: s = mk(OP_MUL,  S_TA,   S_T,   S_TA,   1'b0, CAP_C0,  1'b0);
            6'd37: s = mk(OP_ADD,  S_TA,   S_C3,  S_TA,   1'b1, CAP_VAL, 1'b1);
            default: s = mk(OP_ADD, S_TA,  S_TA,  S_TA,   1'b0, CAP_C0,  1'b1);
        endcase
        return s;
    endfunction

endpackage

>>> hdl/csi_alu.sv
// Shared saturating Q16.16 arithmetic unit: add family, multiply and bit-serial divide.
module csi_alu
    import csi_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)(
    input  logic         clk,
    input  logic         rst_n,
    input  csi_alu_req_t alu_req,
    output csi_alu_rsp_t alu_rsp
);

    localparam int EFF   = (DATA_WIDTH < 16) ? 16 : ((DATA_WIDTH > 32) ? 32 : DATA_WIDTH);
    localparam int SAT_W = 50;
    localparam int NUM_W = 48;
    localparam longint HI_L = (longint'(1) << (EFF - 1)) - 1;
    localparam logic signed [SAT_W-1:0] HI = SAT_W'(HI_L);
    localparam logic signed [SAT_W-1:0] LO = -HI - SAT_W'(1);

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_DIVF
    } a_state_t;

    a_state_t           state_reg;
    logic               done_reg;
    logic signed [31:0] res_reg;
    logic               sat_reg;
    logic               zero_reg;
    logic signed [63:0] prod_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [NUM_W-1:0]   quo_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        den_reg;
    logic               neg_reg;
    logic [5:0]         cnt_reg;

    logic signed [SAT_W-1:0] ea;
    logic signed [SAT_W-1:0] eb;
    logic signed [SAT_W-1:0] add_val;
    logic signed [SAT_W-1:0] pre;
    logic signed [SAT_W-1:0] sat_val;
    logic                    sat_hit;
    logic                    commit;
    logic [32:0]             trial;
    logic [31:0]             abs_a;
    logic [31:0]             abs_b;
    logic signed [SAT_W-1:0] quo_ext;

    always_comb
    begin
        ea = SAT_W'(alu_req.a);
        eb = SAT_W'(alu_req.b);
        case (alu_req.op)
            OP_ADD:  add_val = ea + eb;
            OP_SUB:  add_val = ea - eb;
            OP_SUB2: add_val = ea - (eb <<< 1);
            OP_TRI:  add_val = (ea <<< 1) + ea - eb;
            default: add_val = ea + eb;
        endcase
        abs_a   = alu_req.a[31] ? 32'(-alu_req.a) : alu_req.a;
        abs_b   = alu_req.b[31] ? 32'(-alu_req.b) : alu_req.b;
        trial   = {rem_reg, num_reg[NUM_W-1]};
        quo_ext = SAT_W'({2'b00, quo_reg});
        pre     = '0;
        commit  = 1'b0;
        unique case (state_reg)
            A_IDLE:
            begin
                if (alu_req.start && alu_req.op != OP_MUL && alu_req.op != OP_DIV)
                begin
                    pre    = add_val;
                    commit = 1'b1;
                end
                else if (alu_req.start && alu_req.op == OP_DIV && alu_req.b == '0)
                begin
                    commit = 1'b1;
                end
            end
            A_MUL:
            begin
                pre    = SAT_W'(prod_reg >>> 16);
                commit = 1'b1;
            end
            A_DIV:
            begin
            end
            A_DIVF:
            begin
                pre    = neg_reg ? -quo_ext : quo_ext;
                commit = 1'b1;
            end
            default:
            begin
            end
        endcase
        sat_hit = (pre > HI) || (pre < LO);
        sat_val = (pre > HI) ? HI : ((pre < LO) ? LO : pre);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= commit;
            if (commit)
            begin
                res_reg  <= sat_val[31:0];
                sat_reg  <= sat_hit;
                zero_reg <= (state_reg == A_IDLE) && (alu_req.op == OP_DIV);
            end
            unique case (state_reg)
                A_IDLE:
                begin
                    if (alu_req.start && alu_req.op == OP_MUL)
                    begin
                        prod_reg  <= alu_req.a * alu_req.b;
                        state_reg <= A_MUL;
                    end
                    else if (alu_req.start && alu_req.op == OP_DIV && alu_req.b != '0)
                    begin
                        num_reg   <= {abs_a, 16'd0};
                        den_reg   <= abs_b;
                        neg_reg   <= alu_req.a[31] ^ alu_req.b[31];
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= 6'(NUM_W - 1);
                        state_reg <= A_DIV;
                    end
                end
                A_MUL:
                begin
                    state_reg <= A_IDLE;
                end
                A_DIV:
                begin
                    num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                    if (trial >= {1'b0, den_reg})
                    begin
                        rem_reg <= 32'(trial - {1'b0, den_reg});
                        quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial[31:0];
                        quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= A_DIVF;
                    end
                end
                A_DIVF:
                begin
                    state_reg <= A_IDLE;
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign alu_rsp.done   = done_reg;
    assign alu_rsp.result = res_reg;
    assign alu_rsp.sat    = sat_reg;
    assign alu_rsp.zero   = zero_reg;

endmodule

>>> hdl/cubic_spline_segment_interp.sv
// Top level of the cubic spline segment interpolator: sequencer, scratch memory and coefficient store.
//
// Requests enter on req_valid/req_data and are taken when req_stall is low;
// results leave on rsp_valid/rsp_data and are taken when rsp_stall is low.
// A load request (req_type 0) brings four points, computes the four
// coefficients of the middle segment, stores them unless a divide by
// zero occurs, and returns the stored coefficients with status.
// An evaluate request (req_type 1) returns the stored cubic at eval_offset.
// One request is worked at a time; req_stall stays high until it finishes.
// A load's running time is dominated by its seven bit-serial divides in
// the shared unit. Each program step passes through a scratch read, an
// issue and a wait for the arithmetic unit's result.
// A finished result waits in the output register while rsp_stall is high;
// a new request may be taken then, and its result waits for the slot.
// Reset clears the coefficient store to zero and drops rsp_valid.
module cubic_spline_segment_interp
    import csi_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  csi_req_t req_data,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output csi_rsp_t rsp_data
);

    localparam int EFF = (DATA_WIDTH < 16) ? 16 : ((DATA_WIDTH > 32) ? 32 : DATA_WIDTH);
    localparam longint HI_L = (longint'(1) << (EFF - 1)) - 1;
    localparam logic signed [31:0] HI32 = 32'(HI_L);
    localparam logic signed [31:0] LO32 = -HI32 - 32'sd1;
    localparam int DEPTH = 1 << SLOT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_READ,
        S_ISSUE,
        S_WAIT,
        S_FINISH
    } state_t;

    function automatic logic signed [31:0] sat_in(input logic signed [31:0] v);
        logic signed [31:0] r;
        r = v;
        if (v > HI32)
        begin
            r = HI32;
        end
        else if (v < LO32)
        begin
            r = LO32;
        end
        return r;
    endfunction

    state_t             state_reg;
    csi_req_t           req_reg;
    logic [3:0]         idx_reg;
    logic [PC_W-1:0]    pc_reg;
    logic               sat_acc_reg;
    logic               zero_acc_reg;
    logic signed [31:0] coef_reg [4];
    logic signed [31:0] newc_reg [3];
    logic signed [31:0] val_reg;
    logic               rsp_valid_reg;
    csi_rsp_t           rsp_reg;
    logic signed [31:0] rda_reg;
    logic signed [31:0] rdb_reg;
    logic signed [31:0] scratch_mem [DEPTH];

    csi_step_t          step;
    csi_alu_req_t       alu_req;
    csi_alu_rsp_t       alu_rsp;
    logic               mem_we;
    logic [SLOT_W-1:0]  mem_wa;
    logic signed [31:0] mem_wd;
    logic signed [31:0] init_wd;
    logic               accept;
    logic               slot_free;
    logic signed [31:0] coef_next [4];
    csi_rsp_t           rsp_next;

    csi_alu #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_alu (
        .clk     (clk),
        .rst_n   (rst_n),
        .alu_req (alu_req),
        .alu_rsp (alu_rsp)
    );

    assign step      = prog_step(pc_reg);
    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    assign alu_req.start = (state_reg == S_ISSUE);
    assign alu_req.op    = step.op;
    assign alu_req.a     = rda_reg;
    assign alu_req.b     = rdb_reg;

    always_comb
    begin
        case (idx_reg)
            4'd0:    init_wd = sat_in(req_reg.point_x0);
            4'd1:    init_wd = sat_in(req_reg.point_x1);
            4'd2:    init_wd = sat_in(req_reg.point_x2);
            4'd3:    init_wd = sat_in(req_reg.point_x3);
            4'd4:    init_wd = sat_in(req_reg.point_y0);
            4'd5:    init_wd = sat_in(req_reg.point_y1);
            4'd6:    init_wd = sat_in(req_reg.point_y2);
            4'd7:    init_wd = sat_in(req_reg.point_y3);
            4'd8:    init_wd = sat_in(req_reg.eval_offset);
            4'd9:    init_wd = coef_reg[0];
            4'd10:   init_wd = coef_reg[1];
            4'd11:   init_wd = coef_reg[2];
            4'd12:   init_wd = coef_reg[3];
            default: init_wd = '0;
        endcase
        if (state_reg == S_INIT)
        begin
            mem_we = 1'b1;
            mem_wa = SLOT_W'(idx_reg);
            mem_wd = init_wd;
        end
        else
        begin
            mem_we = (state_reg == S_WAIT) && alu_rsp.done;
            mem_wa = step.dst;
            mem_wd = alu_rsp.result;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            coef_next[i] = coef_reg[i];
        end
        rsp_next.interp_value = '0;
        rsp_next.status       = sat_acc_reg ? STAT_SAT : STAT_OK;
        if (req_reg.req_type == REQ_LOAD)
        begin
            if (zero_acc_reg)
            begin
                rsp_next.status = STAT_ZERO;
            end
            else
            begin
                coef_next[0] = newc_reg[0];
                coef_next[1] = newc_reg[1];
                coef_next[2] = newc_reg[2];
                coef_next[3] = sat_in(req_reg.point_y1);
            end
        end
        else
        begin
            rsp_next.interp_value = val_reg;
        end
        rsp_next.coef_cubic     = coef_next[0];
        rsp_next.coef_quadratic = coef_next[1];
        rsp_next.coef_linear    = coef_next[2];
        rsp_next.coef_constant  = coef_next[3];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            scratch_mem[mem_wa] <= mem_wd;
        end
        if (state_reg == S_READ)
        begin
            rda_reg <= scratch_mem[step.src_a];
            rdb_reg <= scratch_mem[step.src_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            idx_reg       <= '0;
            pc_reg        <= '0;
            sat_acc_reg   <= 1'b0;
            zero_acc_reg  <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && (state_reg != S_FINISH))
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg   <= req_data;
                        idx_reg   <= '0;
                        state_reg <= S_INIT;
                    end
                end
                S_INIT:
                begin
                    idx_reg <= idx_reg + 4'd1;
                    if (idx_reg == INIT_LAST)
                    begin
                        pc_reg       <= (req_reg.req_type == REQ_EVAL) ? PC_EVAL : PC_LOAD;
                        sat_acc_reg  <= 1'b0;
                        zero_acc_reg <= 1'b0;
                        state_reg    <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_ISSUE;
                end
                S_ISSUE:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (alu_rsp.done)
                    begin
                        sat_acc_reg  <= sat_acc_reg | alu_rsp.sat;
                        zero_acc_reg <= zero_acc_reg | alu_rsp.zero;
                        if (step.cap_en)
                        begin
                            case (step.cap)
                                CAP_C0:  newc_reg[0] <= alu_rsp.result;
                                CAP_C1:  newc_reg[1] <= alu_rsp.result;
                                CAP_C2:  newc_reg[2] <= alu_rsp.result;
                                default: val_reg     <= alu_rsp.result;
                            endcase
                        end
                        if (step.last)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            pc_reg    <= pc_reg + 6'd1;
                            state_reg <= S_READ;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (slot_free)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            coef_reg[i] <= coef_next[i];
                        end
                        rsp_reg       <= rsp_next;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

>>> verif/tb.sv
// Self-checking testbench for the cubic spline segment interpolator: directed and random loads and evaluates.
module tb;
    import csi_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    csi_req_t req_data;
    logic     rsp_valid;
    logic     rsp_stall;
    csi_rsp_t rsp_data;

    cubic_spline_segment_interp u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    localparam longint MAX_Q = 64'sd2147483647;
    localparam longint MIN_Q = -64'sd2147483648;
    localparam longint ONE_Q = 64'sd65536;

    longint   coef_store [4];
    bit       sat_seen;
    bit       zero_seen;
    csi_rsp_t spline_expected [$];
    int       n_errors;
    longint   cycle_count;
    int       burst_left;
    int       rsp_mode;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint clamp_q(input longint v);
        if (v > MAX_Q)
        begin
            sat_seen = 1'b1;
            return MAX_Q;
        end
        if (v < MIN_Q)
        begin
            sat_seen = 1'b1;
            return MIN_Q;
        end
        return v;
    endfunction

    function automatic longint mul_q(input longint a, input longint b);
        return clamp_q((a * b) >>> 16);
    endfunction

    function automatic longint div_q(input longint a, input longint b);
        if (b == 0)
        begin
            zero_seen = 1'b1;
            return 0;
        end
        return clamp_q((a * ONE_Q) / b);
    endfunction

    function automatic csi_rsp_t spline_predict(input csi_req_t rq);
        longint   x [4];
        longint   y [4];
        longint   h [3];
        longint   d [3];
        longint   yd [3];
        longint   num, r, q, hq, h1sq, h1cu, c0, c1, t, acc;
        csi_rsp_t rs;
        x[0] = rq.point_x0; x[1] = rq.point_x1; x[2] = rq.point_x2; x[3] = rq.point_x3;
        y[0] = rq.point_y0; y[1] = rq.point_y1; y[2] = rq.point_y2; y[3] = rq.point_y3;
        sat_seen = 1'b0;
        zero_seen = 1'b0;
        rs.interp_value = '0;
        if (rq.req_type == REQ_LOAD)
        begin
            for (int i = 0; i < 3; i++)
                h[i] = clamp_q(x[i+1] - x[i]);
            for (int i = 0; i < 3; i++)
                d[i] = div_q(clamp_q(y[i+1] - y[i]), h[i]);
            yd[0] = 0;
            for (int i = 1; i < 3; i++)
            begin
                num = clamp_q(mul_q(d[i], h[i-1]) + mul_q(d[i-1], h[i]));
                yd[i] = div_q(num, clamp_q(h[i-1] + h[i]));
            end
            r = clamp_q(clamp_q(y[2] - y[1]) - mul_q(h[1], yd[1]));
            q = clamp_q(yd[2] - yd[1]);
            hq = mul_q(h[1], q);
            h1sq = mul_q(h[1], h[1]);
            h1cu = mul_q(h1sq, h[1]);
            c0 = div_q(clamp_q(hq - 2 * r), h1cu);
            c1 = div_q(clamp_q(3 * r - hq), h1sq);
            if (zero_seen)
                rs.status = STAT_ZERO;
            else
            begin
                coef_store[0] = c0;
                coef_store[1] = c1;
                coef_store[2] = yd[1];
                coef_store[3] = y[1];
                rs.status = sat_seen ? STAT_SAT : STAT_OK;
            end
        end
        else
        begin
            t = rq.eval_offset;
            acc = clamp_q(coef_store[1] + mul_q(coef_store[0], t));
            acc = clamp_q(coef_store[2] + mul_q(t, acc));
            acc = clamp_q(coef_store[3] + mul_q(t, acc));
            rs.interp_value = acc[31:0];
            rs.status = sat_seen ? STAT_SAT : STAT_OK;
        end
        rs.coef_cubic     = coef_store[0][31:0];
        rs.coef_quadratic = coef_store[1][31:0];
        rs.coef_linear    = coef_store[2][31:0];
        rs.coef_constant  = coef_store[3][31:0];
        return rs;
    endfunction

    task automatic send_request(input csi_req_t rq);
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 6) == 0 ? $urandom_range(1, 40) : $urandom_range(1, 2))
                @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        req_valid <= 1'b1;
        req_data  <= rq;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        spline_expected.push_back(spline_predict(rq));
        burst_left--;
    endtask

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh7fffffff - $urandom_range(0, 3);
            2: return 32'sh80000000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
        endcase
    endfunction

    function automatic csi_req_t make_load();
        csi_req_t rq;
        longint   xs;
        rq = '0;
        rq.req_type = REQ_LOAD;
        if ($urandom_range(0, 9) < 8)
        begin
            xs = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
            rq.point_x0 = 32'(xs);
            rq.point_x1 = rq.point_x0 + $urandom_range(1, 32'h00040000);
            rq.point_x2 = rq.point_x1 + $urandom_range(1, 32'h00040000);
            rq.point_x3 = rq.point_x2 + $urandom_range(1, 32'h00040000);
            rq.point_y0 = $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
            rq.point_y1 = $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
            rq.point_y2 = $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
            rq.point_y3 = $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
        end
        else
        begin
            rq.point_x0 = rand_q(); rq.point_x1 = rand_q();
            rq.point_x2 = rand_q(); rq.point_x3 = rand_q();
            rq.point_y0 = rand_q(); rq.point_y1 = rand_q();
            rq.point_y2 = rand_q(); rq.point_y3 = rand_q();
            if ($urandom_range(0, 3) == 0)
                rq.point_x2 = rq.point_x1;
        end
        rq.eval_offset = $urandom;
        return rq;
    endfunction

    function automatic csi_req_t make_eval();
        csi_req_t rq;
        rq = '0;
        rq.req_type = REQ_EVAL;
        rq.point_x0 = $urandom; rq.point_x1 = $urandom;
        rq.point_x2 = $urandom; rq.point_x3 = $urandom;
        rq.point_y0 = $urandom; rq.point_y1 = $urandom;
        rq.point_y2 = $urandom; rq.point_y3 = $urandom;
        rq.eval_offset = ($urandom_range(0, 4) == 0) ? rand_q()
                       : $signed($urandom_range(0, 32'h00080000)) - 32'sh00040000;
        return rq;
    endfunction

    task automatic drain_results();
        req_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (spline_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        csi_req_t           rq;
        logic signed [31:0] offs [6];
        offs = '{32'sh00000000, 32'sh00008000, 32'sh00010000, 32'shffff0000,
                 32'sh7fffffff, 32'sh80000000};
        rq = '0;
        rq.req_type = REQ_EVAL;
        rq.eval_offset = 32'sh00010000;
        send_request(rq);
        rq = '0;
        rq.req_type = REQ_LOAD;
        rq.point_x0 = 32'sh00000000; rq.point_x1 = 32'sh00010000;
        rq.point_x2 = 32'sh00020000; rq.point_x3 = 32'sh00030000;
        rq.point_y0 = 32'sh00000000; rq.point_y1 = 32'sh00010000;
        rq.point_y2 = 32'sh00040000; rq.point_y3 = 32'sh00090000;
        send_request(rq);
        foreach (offs[i])
        begin
            rq.req_type = REQ_EVAL;
            rq.eval_offset = offs[i];
            send_request(rq);
        end
        rq = '0;
        rq.req_type = REQ_LOAD;
        rq.point_x1 = 32'sh00010000;
        rq.point_x2 = 32'sh00010000;
        rq.point_x3 = 32'sh00020000;
        send_request(rq);
        rq.point_x0 = 32'sh00010000;
        rq.point_x2 = 32'sh00020000;
        send_request(rq);
        rq = '0;
        rq.req_type = REQ_LOAD;
        rq.point_x1 = 32'sh00000001;
        rq.point_x2 = 32'sh00000002;
        rq.point_x3 = 32'sh00000003;
        send_request(rq);
        rq.point_x0 = 32'sh80000000;
        rq.point_x1 = 32'shc0000000;
        rq.point_x2 = 32'sh40000000;
        rq.point_x3 = 32'sh7fffffff;
        rq.point_y0 = 32'sh7fffffff;
        rq.point_y1 = 32'sh80000000;
        rq.point_y2 = 32'sh7fffffff;
        rq.point_y3 = 32'sh80000000;
        send_request(rq);
        rq.req_type = REQ_EVAL;
        rq.eval_offset = 32'sh7fffffff;
        send_request(rq);
        rq = '1;
        rq.req_type = REQ_LOAD;
        send_request(rq);
        send_request(make_load());
        send_request(make_eval());
    endtask

    task automatic test_quiet_pause();
        drain_results();
        send_request(make_eval());
        send_request(make_load());
    endtask

    task automatic test_random();
        for (int n = 0; n < 1300; n++)
            send_request($urandom_range(0, 2) == 0 ? make_load() : make_eval());
    endtask

    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
        begin
            if (spline_expected.size() == 0)
            begin
                $display("%0t: unexpected response %h", $time, rsp_data);
                n_errors++;
            end
            else
            begin
                if (rsp_data !== spline_expected[0])
                begin
                    $display("%0t: mismatch expected %h actual %h", $time,
                             spline_expected[0], rsp_data);
                    n_errors++;
                end
                void'(spline_expected.pop_front());
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_mode  <= 0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                rsp_mode <= $urandom_range(0, 2);
            case (rsp_mode)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= ($urandom_range(0, 3) == 0);
                default: rsp_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 64'd3000000)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_data    = '0;
        n_errors    = 0;
        cycle_count = 0;
        burst_left  = 0;
        coef_store  = '{default: 0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_quiet_pause();
        test_random();
        drain_results();
        repeat (500) @(posedge clk);
        if (n_errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
